### src/npcs_pkg.sv
// Shared types and constants for the nearest palette color search block.
// No dependencies; every other file of the block imports this package.
package npcs_pkg;

	localparam int PALETTE_DEPTH = 64;
	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int CH_W = 16;
	localparam int CNT_W = 7;
	localparam int DIST_W = 34;
	localparam int SQ_W = 2 * CH_W;

	localparam logic [CNT_W-1:0] ENTRIES_RESET = CNT_W'(61);
	localparam logic [DIST_W-1:0] THRESHOLD_RESET = DIST_W'(42948362);

	// Configuration register indexes.
	localparam logic REG_ENTRIES_IN_USE = 1'b0;
	localparam logic REG_CLOSE_THRESHOLD = 1'b1;

	// Input word kinds.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} color_t;

	// Travels beside each palette read through the distance pipeline.
	typedef struct packed {
		logic vld;
		logic last;
		logic [IDX_W-1:0] idx;
	} scan_tag_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} scan_state_t;

endpackage

### src/npcs_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on npcs_pkg for widths.
interface npcs_req_if import npcs_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic [5:0] entry_index;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, kind, entry_index, red, green, blue, input ready);
	modport sink (input valid, kind, entry_index, red, green, blue, output ready);
endinterface

interface npcs_rsp_if import npcs_pkg::*; ();
	logic valid;
	logic ready;
	logic [5:0] best_index;
	logic [DIST_W-1:0] best_distance;
	logic bypassed;
	logic stopped_early;

	modport source (output valid, best_index, best_distance, bypassed, stopped_early,
		input ready);
	modport sink (input valid, best_index, best_distance, bypassed, stopped_early,
		output ready);
endinterface

### src/nearest_palette_color_search_top.sv
// Top level of the nearest palette color search: control, registers, output stage.
// Depends on npcs_pkg, npcs_if, npcs_palette_ram and npcs_dist_pipe.
//
//  Channel  Direction  Handshake     Carries
//  req      in         valid/ready   kind, entry_index, red, green, blue
//  rsp      out        valid/ready   best_index, best_distance, bypassed, stopped_early
//  cfg      in         cfg_we        cfg_index, cfg_data
//
// A query reads one palette entry per cycle from the RAM read port and passes
// each through the four-stage distance pipeline. A query with zero entries in use
// skips the scan. Reset is asynchronous, needs no clearing pass, and leaves the
// registers at 61 entries and the default threshold. A result waiting in the output
// register blocks load words only while a finished query waits to take its place.
module nearest_palette_color_search_top import npcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	npcs_req_if.sink          req,
	npcs_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIST_W-1:0] cfg_data
);

	scan_state_t state_q, state_d;

	logic [CNT_W-1:0] entries_q;
	logic [DIST_W-1:0] thr_q;

	color_t qcol_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] addr_q;
	logic issued_all_q;
	logic have_q;

	logic [IDX_W-1:0] best_idx_q;
	logic [DIST_W-1:0] best_dist_q;
	logic bypass_q;
	logic early_q;

	logic out_vld_q;
	logic [5:0] out_idx_q;
	logic [DIST_W-1:0] out_dist_q;
	logic out_bypass_q;
	logic out_early_q;

	logic req_fire, load_fire, query_fire;
	logic issue, flush, out_load, last_issue;
	logic better, stop;
	scan_tag_t tag_in, tag_s4;
	color_t entry_rd, wr_color;
	logic [DIST_W-1:0] dist_s4;

	assign req_fire = req.valid && req.ready;
	assign load_fire = req_fire && (req.kind == KIND_LOAD);
	assign query_fire = req_fire && (req.kind == KIND_QUERY);
	assign wr_color = '{r: req.red, g: req.green, b: req.blue};

	assign last_issue = (addr_q + CNT_W'(1)) == limit_q;
	assign tag_in = '{vld: issue, last: last_issue, idx: addr_q[IDX_W-1:0]};

	// The first entry always becomes the best; later ones only when strictly closer.
	assign better = tag_s4.vld && (!have_q || (dist_s4 < best_dist_q));
	assign stop = better && (dist_s4 <= thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRIES_IN_USE: entries_q <= cfg_data[CNT_W-1:0];
				REG_CLOSE_THRESHOLD: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		issue = 1'b0;
		flush = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (query_fire) begin
					state_d = (entries_q == '0) ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = !issued_all_q;
				if (tag_s4.vld && (stop || tag_s4.last)) begin
					flush = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_all_q <= 1'b0;
			have_q <= 1'b0;
			early_q <= 1'b0;
			bypass_q <= 1'b0;
		end else if (query_fire) begin
			issued_all_q <= 1'b0;
			have_q <= 1'b0;
			early_q <= 1'b0;
			bypass_q <= (entries_q == '0);
		end else begin
			if (issue && last_issue) begin
				issued_all_q <= 1'b1;
			end
			if (better) begin
				have_q <= 1'b1;
			end
			if (stop) begin
				early_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			qcol_q <= wr_color;
			addr_q <= '0;
			limit_q <= (entries_q > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : entries_q;
			best_idx_q <= '0;
			best_dist_q <= '0;
		end else begin
			if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			if (better) begin
				best_idx_q <= tag_s4.idx;
				best_dist_q <= dist_s4;
			end
		end
	end

	// Output register: the response word stays here until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q <= 6'(best_idx_q);
			out_dist_q <= best_dist_q;
			out_bypass_q <= bypass_q;
			out_early_q <= early_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.best_index = out_idx_q;
	assign rsp.best_distance = out_dist_q;
	assign rsp.bypassed = out_bypass_q;
	assign rsp.stopped_early = out_early_q;

	npcs_palette_ram u_ram (
		.clk   (clk),
		.we    (load_fire),
		.waddr (req.entry_index[IDX_W-1:0]),
		.wdata (wr_color),
		.re    (issue),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (entry_rd)
	);

	npcs_dist_pipe u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.flush   (flush),
		.tag_in  (tag_in),
		.entry   (entry_rd),
		.query   (qcol_q),
		.tag_s4  (tag_s4),
		.dist_s4 (dist_s4)
	);

endmodule

### src/npcs_palette_ram.sv
// Palette storage: one write port and one read port with registered read data.
// Depends on npcs_pkg for depth and the color type.
module npcs_palette_ram import npcs_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  color_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output color_t           rdata
);

	color_t mem [PALETTE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/npcs_dist_pipe.sv
// Squared distance pipeline: absolute differences, squares, then the sum.
// Depends on npcs_pkg; its first stage lines up with the palette RAM read register.
module npcs_dist_pipe import npcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              flush,
	input  scan_tag_t         tag_in,
	input  color_t            entry,
	input  color_t            query,
	output scan_tag_t         tag_s4,
	output logic [DIST_W-1:0] dist_s4
);

	scan_tag_t tag_s1, tag_s2, tag_s3;
	logic [CH_W-1:0] dr_s2, dg_s2, db_s2;
	logic [SQ_W-1:0] sr_s3, sg_s3, sb_s3;

	function automatic logic [CH_W-1:0] abs_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (flush) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		dr_s2 <= abs_diff(entry.r, query.r);
		dg_s2 <= abs_diff(entry.g, query.g);
		db_s2 <= abs_diff(entry.b, query.b);
		sr_s3 <= SQ_W'(dr_s2) * SQ_W'(dr_s2);
		sg_s3 <= SQ_W'(dg_s2) * SQ_W'(dg_s2);
		sb_s3 <= SQ_W'(db_s2) * SQ_W'(db_s2);
		dist_s4 <= DIST_W'(sr_s3) + DIST_W'(sg_s3) + DIST_W'(sb_s3);
	end

endmodule

### tb/nearest_palette_color_search_top_tb.sv
// Self-checking testbench for nearest_palette_color_search_top: palette loads and nearest
// color queries against a built-in predictor of the search. Depends on npcs_pkg, the
// npcs_req_if/npcs_rsp_if interfaces and the RTL from the top level down.
module nearest_palette_color_search_top_tb import npcs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 400;
	localparam int LAT_PAD = 80;
	localparam int QUIET_LIMIT = 5000;

	typedef struct packed {
		logic kind;
		logic [IDX_W-1:0] entry_index;
		color_t col;
	} pal_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] best_index;
		logic [DIST_W-1:0] best_distance;
		logic bypassed;
		logic stopped_early;
	} match_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [DIST_W-1:0] cfg_data;

	npcs_req_if req_ch ();
	npcs_rsp_if rsp_ch ();

	nearest_palette_color_search_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state, updated as words are accepted and registers are written.
	color_t pal_shadow [PALETTE_DEPTH];
	logic [CNT_W-1:0] entries_cfg = ENTRIES_RESET;
	logic [DIST_W-1:0] thresh_cfg = THRESHOLD_RESET;

	// Palette as the generator last wrote it, used to aim queries near entries.
	color_t gen_pal [PALETTE_DEPTH];

	pal_word_t pending_words [$];
	pal_word_t in_flight;
	match_t expected_matches [$];

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	logic hold_go = 1'b0;
	int hold_count = 0;
	int quiet_cycles = 0;
	int fail_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [SQ_W-1:0] chan_sq(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		logic [SQ_W-1:0] diff;
		diff = (a >= b) ? a - b : b - a;
		return diff * diff;
	endfunction

	// Scans the shadow palette the way the block does: first strict minimum wins,
	// and the scan ends at the first new minimum that meets the threshold.
	function automatic match_t search_palette(input color_t c);
		match_t m;
		int unsigned lim;
		logic [DIST_W-1:0] d;
		m = '0;
		if (entries_cfg == '0) begin
			m.bypassed = 1'b1;
			return m;
		end
		lim = (entries_cfg > PALETTE_DEPTH) ? PALETTE_DEPTH : entries_cfg;
		for (int unsigned i = 0; i < lim; i++) begin
			d = DIST_W'(chan_sq(pal_shadow[i].r, c.r)) + DIST_W'(chan_sq(pal_shadow[i].g, c.g))
				+ DIST_W'(chan_sq(pal_shadow[i].b, c.b));
			if (i == 0 || d < m.best_distance) begin
				m.best_index = IDX_W'(i);
				m.best_distance = d;
				if (d <= thresh_cfg) begin
					m.stopped_early = 1'b1;
					break;
				end
			end
		end
		return m;
	endfunction

	function automatic logic [CH_W-1:0] nudge(input logic [CH_W-1:0] v, input int spread);
		int t;
		t = int'(v) + int'($urandom_range(2 * spread)) - spread;
		if (t < 0)
			t = 0;
		if (t > 65535)
			t = 65535;
		return CH_W'(t);
	endfunction

	// Mix of uniform colors, corner colors, exact copies and near copies of entries.
	function automatic color_t pick_color();
		color_t c;
		int unsigned j;
		int spread;
		j = $urandom_range(PALETTE_DEPTH - 1);
		spread = 4 << (3 * $urandom_range(4));
		case ($urandom_range(9))
			0, 1, 2: begin
				c.r = CH_W'($urandom);
				c.g = CH_W'($urandom);
				c.b = CH_W'($urandom);
			end
			3: begin
				c.r = $urandom_range(1) ? '1 : '0;
				c.g = $urandom_range(1) ? '1 : '0;
				c.b = $urandom_range(1) ? '1 : '0;
			end
			4: c = gen_pal[j];
			default: begin
				c.r = nudge(gen_pal[j].r, spread);
				c.g = nudge(gen_pal[j].g, spread);
				c.b = nudge(gen_pal[j].b, spread);
			end
		endcase
		return c;
	endfunction

	task automatic push_load(input int unsigned idx, input color_t c);
		pal_word_t w;
		w.kind = KIND_LOAD;
		w.entry_index = IDX_W'(idx);
		w.col = c;
		gen_pal[idx] = c;
		pending_words.push_back(w);
	endtask

	task automatic push_query(input color_t c);
		pal_word_t w;
		w.kind = KIND_QUERY;
		w.entry_index = IDX_W'($urandom);
		w.col = c;
		pending_words.push_back(w);
	endtask

	task automatic gen_random(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 45)
				push_load($urandom_range(PALETTE_DEPTH - 1), pick_color());
			else
				push_query(pick_color());
		end
	endtask

	// Writes both registers on back-to-back edges; the block must be idle.
	task automatic set_regs(input logic [CNT_W-1:0] cnt, input logic [DIST_W-1:0] thr);
		logic [DIST_W-1:0] junk;
		junk = DIST_W'({$urandom, $urandom});
		junk[CNT_W-1:0] = cnt;
		cfg_we <= 1'b1;
		cfg_index <= REG_ENTRIES_IN_USE;
		cfg_data <= junk;
		@(posedge clk);
		entries_cfg = cnt;
		cfg_index <= REG_CLOSE_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		thresh_cfg = thr;
		cfg_we <= 1'b0;
	endtask

	// Loads produce no result, so the task keeps waiting after the queues empty to let the last one finish.
	task automatic wait_drained();
		while (pending_words.size() != 0 || req_ch.valid || expected_matches.size() != 0)
			@(posedge clk);
		repeat (LAT_PAD) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : req_drv
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= KIND_LOAD;
			req_ch.entry_index <= '0;
			req_ch.red <= '0;
			req_ch.green <= '0;
			req_ch.blue <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				if (in_flight.kind == KIND_LOAD)
					pal_shadow[in_flight.entry_index] = in_flight.col;
				else
					expected_matches.push_back(search_palette(in_flight.col));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
					in_flight = pending_words.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.kind <= in_flight.kind;
					req_ch.entry_index <= in_flight.entry_index;
					req_ch.red <= in_flight.col.r;
					req_ch.green <= in_flight.col.g;
					req_ch.blue <= in_flight.col.b;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rsp_mon
		match_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_matches.size() == 0) begin
					$error("unexpected result word: best_index %0d best_distance %0d",
						rsp_ch.best_index, rsp_ch.best_distance);
					fail_count++;
				end else begin
					want = expected_matches.pop_front();
					if (rsp_ch.best_index !== want.best_index) begin
						$error("best_index: expected %0d, got %0d", want.best_index,
							rsp_ch.best_index);
						fail_count++;
					end
					if (rsp_ch.best_distance !== want.best_distance) begin
						$error("best_distance: expected %0d, got %0d", want.best_distance,
							rsp_ch.best_distance);
						fail_count++;
					end
					if (rsp_ch.bypassed !== want.bypassed) begin
						$error("bypassed: expected %0b, got %0b", want.bypassed,
							rsp_ch.bypassed);
						fail_count++;
					end
					if (rsp_ch.stopped_early !== want.stopped_early) begin
						$error("stopped_early: expected %0b, got %0b", want.stopped_early,
							rsp_ch.stopped_early);
						fail_count++;
					end
				end
			end
			// One long hold-off lets results back up until the block stalls its input.
			if (hold_go && hold_count < HOLD_CYCLES) begin
				hold_count++;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n && !(req_ch.valid && req_ch.ready) && !(rsp_ch.valid && rsp_ch.ready)
			&& !cfg_we)
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("nearest_palette_color_search_top regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		color_t c;
		logic [CNT_W-1:0] cnt;
		logic [DIST_W-1:0] thr;
		int m;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENTRIES_IN_USE;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every entry first so no query can ever reach an unwritten one.
		// Black sits at entry 0, white at the top, and entry 20 repeats entry 10.
		for (int i = 0; i < PALETTE_DEPTH; i++) begin
			c.r = CH_W'($urandom);
			c.g = CH_W'($urandom);
			c.b = CH_W'($urandom);
			if (i == 0)
				c = '0;
			else if (i == PALETTE_DEPTH - 1)
				c = '1;
			else if (i == 20)
				c = gen_pal[10];
			push_load(i, c);
		end
		push_query('0);
		push_query('1);
		push_query(gen_pal[20]);
		push_query({16'h0000, 16'hFFFF, 16'h0000});
		wait_drained();

		for (int p = 1; p <= 8; p++) begin
			case (p)
				1: begin cnt = 7'd64; thr = '0; end
				2: begin cnt = 7'd0; thr = THRESHOLD_RESET; end
				3: begin cnt = 7'd1; thr = DIST_W'(64'd12884508675); end
				4: begin cnt = 7'd127; thr = DIST_W'($urandom_range(50000000)); end
				5: begin cnt = 7'd64; thr = THRESHOLD_RESET; end
				6: begin cnt = 7'd32; thr = '0; end
				7: begin cnt = 7'd64; thr = '1; end
				default: begin
					cnt = CNT_W'($urandom_range(1, PALETTE_DEPTH));
					thr = {2'($urandom_range(2)), 32'($urandom)};
				end
			endcase
			set_regs(cnt, thr);
			m = (p - 1) % 4;
			idle_pct = (m == 1) ? 86 : (m == 3) ? 35 : 0;
			stall_pct = (m == 2) ? 86 : (m == 3) ? 35 : 0;
			if (p == 1) begin
				// Zero threshold: exact matches stop early, the near tie picks entry 10.
				c = gen_pal[10];
				c.r = (c.r == '1) ? c.r - 1'b1 : c.r + 1'b1;
				push_query(c);
				push_query('1);
				push_query('0);
				push_query({16'hFFFF, 16'h0000, 16'hFFFF});
				push_query({16'h8000, 16'h7FFF, 16'h0001});
			end
			if (p == 5)
				hold_go = 1'b1;
			gen_random(170);
			wait_drained();
		end

		if (fail_count == 0 && expected_matches.size() == 0)
			$display("nearest_palette_color_search_top regression: pass");
		else
			$display("nearest_palette_color_search_top regression: fail");
		$finish;
	end

endmodule

### nearest_palette_color_search_top.f
src/npcs_pkg.sv
src/npcs_if.sv
src/npcs_palette_ram.sv
src/npcs_dist_pipe.sv
src/nearest_palette_color_search_top.sv
tb/nearest_palette_color_search_top_tb.sv
